/* hdl/fllp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fllp_pkg;

    // Longest line accepted; longer lines get the too-long verdict
    localparam int MAX_LINE   = 1024;
    localparam int POS_W      = $clog2(MAX_LINE + 2);
    localparam int MIN_LINE   = 51;
    localparam int PREFIX_LEN = 13;
    localparam int HASH_DIGITS = 32;

    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam logic [32:0] SIZE_SAT = 33'h1_0000_0000;

    localparam logic [3:0] ERR_OK        = 4'd0;
    localparam logic [3:0] ERR_SHORT     = 4'd1;
    localparam logic [3:0] ERR_PREFIX    = 4'd2;
    localparam logic [3:0] ERR_SUFFIX    = 4'd3;
    localparam logic [3:0] ERR_SEPARATOR = 4'd4;
    localparam logic [3:0] ERR_SIZE_TEXT = 4'd5;
    localparam logic [3:0] ERR_EMPTY     = 4'd6;
    localparam logic [3:0] ERR_RANGE     = 4'd7;
    localparam logic [3:0] ERR_HASH      = 4'd8;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd9;

    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_SIZE   = 5'b00100,
        PH_HASH   = 5'b01000,
        PH_CLOSED = 5'b10000
    } t_phase;

    // Line state as it stands after the last character
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic             prefix_bad;
        logic             size_text_bad;
        logic             tail_ok;
        t_phase           phase;
        logic             bar_after_size;
        logic [10:0]      name_count;
        logic [32:0]      size_acc;
        logic [5:0]       hash_count;
        logic             hash_bad;
        logic [127:0]     hash;
    } t_snap;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h65; // e
            4'd1:    ch = 8'h64; // d
            4'd2:    ch = 8'h32; // 2
            4'd3:    ch = 8'h6b; // k
            4'd4:    ch = 8'h3a; // :
            4'd5:    ch = 8'h2f; // /
            4'd6:    ch = 8'h2f; // /
            4'd7:    ch = 8'h7c; // |
            4'd8:    ch = 8'h66; // f
            4'd9:    ch = 8'h69; // i
            4'd10:   ch = 8'h6c; // l
            4'd11:   ch = 8'h65; // e
            4'd12:   ch = 8'h7c; // |
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

endpackage

`default_nettype wire

/* hdl/fllp_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module fllp_scan import fllp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_text_char,
    input  wire logic       i_is_last,
    output t_snap           o_snap
);

    logic [POS_W-1:0] r_pos, n_pos;
    t_phase           r_phase, n_phase;
    logic             r_prefix_bad, n_prefix_bad;
    logic             r_size_text_bad, n_size_text_bad;
    logic [10:0]      r_name_count, n_name_count;
    logic [32:0]      r_size_acc, n_size_acc;
    logic             r_digit_seen, n_digit_seen;
    logic             r_stopped, n_stopped;
    logic [127:0]     r_hash, n_hash;
    logic [5:0]       r_hash_count, n_hash_count;
    logic             r_hash_bad, n_hash_bad;
    logic             r_bar, n_bar;
    logic [7:0]       r_prev, n_prev;

    logic [36:0]      w_acc_mul;
    logic [3:0]       w_nibble;

    assign w_acc_mul = ({4'd0, r_size_acc} << 3) + ({4'd0, r_size_acc} << 1)
                     + {33'd0, i_text_char[3:0]};
    assign w_nibble  = is_digit(i_text_char) ? i_text_char[3:0]
                                             : i_text_char[3:0] + 4'd9;

    always_comb begin
        n_pos           = r_pos;
        n_phase         = r_phase;
        n_prefix_bad    = r_prefix_bad;
        n_size_text_bad = r_size_text_bad;
        n_name_count    = r_name_count;
        n_size_acc      = r_size_acc;
        n_digit_seen    = r_digit_seen;
        n_stopped       = r_stopped;
        n_hash          = r_hash;
        n_hash_count    = r_hash_count;
        n_hash_bad      = r_hash_bad;
        n_bar           = r_bar;
        n_prev          = r_prev;
        if (i_accept) begin
            if (r_pos < POS_W'(MAX_LINE + 1)) begin
                n_pos = r_pos + 1'b1;
            end
            n_prev = i_text_char;
            case (r_phase)
                PH_HASH, PH_CLOSED: begin
                    if (r_hash_count < 6'(HASH_DIGITS)) begin
                        if (is_digit(i_text_char) || is_hex_letter(i_text_char)) begin
                            n_hash = {r_hash[123:0], w_nibble};
                        end else begin
                            n_hash_bad = 1'b1;
                        end
                        n_hash_count = r_hash_count + 1'b1;
                    end
                    if (r_phase == PH_HASH && i_text_char == CH_BAR) begin
                        n_bar   = 1'b1;
                        n_phase = PH_CLOSED;
                    end
                end
                PH_SIZE: begin
                    if (i_text_char == CH_BAR) begin
                        if (!r_digit_seen && !r_prefix_bad) begin
                            n_size_text_bad = 1'b1;
                        end
                        n_phase = PH_HASH;
                    end else if (!r_stopped) begin
                        if (is_digit(i_text_char)) begin
                            // saturate one past the 32-bit range
                            n_size_acc   = (w_acc_mul > {4'd0, SIZE_SAT}) ? SIZE_SAT
                                                                         : w_acc_mul[32:0];
                            n_digit_seen = 1'b1;
                        end else if (r_digit_seen || !is_blank(i_text_char)) begin
                            n_stopped = 1'b1;
                        end
                    end
                end
                PH_NAME: begin
                    if (i_text_char == CH_BAR) begin
                        n_phase = PH_SIZE;
                    end else if (r_name_count != 11'h7ff) begin
                        n_name_count = r_name_count + 1'b1;
                    end
                end
                default: begin
                    if (r_pos < POS_W'(PREFIX_LEN)
                        && i_text_char != prefix_char(r_pos[3:0])) begin
                        n_prefix_bad = 1'b1;
                    end
                    if (r_pos >= POS_W'(PREFIX_LEN - 1)) begin
                        n_phase = PH_NAME;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_snap.len            = n_pos;
        o_snap.prefix_bad     = n_prefix_bad;
        o_snap.size_text_bad  = n_size_text_bad;
        o_snap.tail_ok        = (r_prev == CH_BAR) && (i_text_char == CH_SLASH);
        o_snap.phase          = n_phase;
        o_snap.bar_after_size = n_bar;
        o_snap.name_count     = n_name_count;
        o_snap.size_acc       = n_size_acc;
        o_snap.hash_count     = n_hash_count;
        o_snap.hash_bad       = n_hash_bad;
        o_snap.hash           = n_hash;
    end

    always_ff @(posedge i_clk) begin
        // clear the line state after the last character
        if (!i_rst_n || (i_accept && i_is_last)) begin
            r_pos           <= '0;
            r_phase         <= PH_PREFIX;
            r_prefix_bad    <= 1'b0;
            r_size_text_bad <= 1'b0;
            r_name_count    <= '0;
            r_size_acc      <= '0;
            r_digit_seen    <= 1'b0;
            r_stopped       <= 1'b0;
            r_hash          <= '0;
            r_hash_count    <= '0;
            r_hash_bad      <= 1'b0;
            r_bar           <= 1'b0;
            r_prev          <= '0;
        end else begin
            r_pos           <= n_pos;
            r_phase         <= n_phase;
            r_prefix_bad    <= n_prefix_bad;
            r_size_text_bad <= n_size_text_bad;
            r_name_count    <= n_name_count;
            r_size_acc      <= n_size_acc;
            r_digit_seen    <= n_digit_seen;
            r_stopped       <= n_stopped;
            r_hash          <= n_hash;
            r_hash_count    <= n_hash_count;
            r_hash_bad      <= n_hash_bad;
            r_bar           <= n_bar;
            r_prev          <= n_prev;
        end
    end

endmodule

`default_nettype wire

/* hdl/file_link_line_parser_top.sv */
// Pipeline: the last character of a line is captured in the line state snapshot,
//   then the snapshot moves into the verdict register once the output is free.
// Throughput: one character per cycle; set by the per-character state update.
//   The input stalls only while a snapshot waits behind an untaken verdict.
// Reset: synchronous, active low; clears the line state and the pipeline
//   valids and sets size_limit to 0xFFFFFFFF. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module file_link_line_parser_top import fllp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_text_char,
    input  wire logic         i_is_last,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [31:0]  i_cfg_size_limit,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [3:0]        o_error_code,
    output logic [10:0]       o_name_length,
    output logic [31:0]       o_file_size,
    output logic [63:0]       o_hash_high,
    output logic [63:0]       o_hash_low
);

    logic [31:0]  r_limit;
    t_snap        w_snap;
    t_snap        r_snap;
    logic         r_snap_valid;
    logic         r_out_valid;
    logic         w_out_free;
    logic         w_accept;
    logic [3:0]   w_err;
    logic         w_range_bad;
    logic [3:0]   r_err;
    logic [10:0]  r_name_len;
    logic [31:0]  r_size;
    logic [127:0] r_hash;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = !r_snap_valid || w_out_free;
    assign w_accept   = i_valid && o_ready;

    fllp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_text_char (i_text_char),
        .i_is_last   (i_is_last),
        .o_snap      (w_snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 32'hffff_ffff;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_size_limit;
        end
    end

    assign w_range_bad = (r_snap.size_acc == 33'd0)
                      || (r_snap.size_acc > {1'b0, r_limit});

    always_comb begin
        if (r_snap.len > POS_W'(MAX_LINE)) begin
            w_err = ERR_TOO_LONG;
        end else if (r_snap.len < POS_W'(MIN_LINE)) begin
            w_err = ERR_SHORT;
        end else if (r_snap.prefix_bad) begin
            w_err = ERR_PREFIX;
        end else if (!r_snap.tail_ok) begin
            w_err = ERR_SUFFIX;
        end else if (r_snap.phase == PH_PREFIX || r_snap.phase == PH_NAME
                     || r_snap.phase == PH_SIZE) begin
            w_err = ERR_SEPARATOR;
        end else if (r_snap.size_text_bad) begin
            w_err = ERR_SIZE_TEXT;
        end else if (!r_snap.bar_after_size) begin
            w_err = ERR_SEPARATOR;
        end else if (r_snap.name_count == 11'd0) begin
            w_err = ERR_EMPTY;
        end else if (w_range_bad) begin
            w_err = ERR_RANGE;
        end else if (r_snap.hash_count != 6'(HASH_DIGITS) || r_snap.hash_bad) begin
            w_err = ERR_HASH;
        end else begin
            w_err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept && i_is_last) begin
                r_snap_valid <= 1'b1;
            end else if (w_out_free) begin
                r_snap_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_snap_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_is_last) begin
            r_snap <= w_snap;
        end
        // advance the snapshot into the verdict register
        if (w_out_free && r_snap_valid) begin
            r_err      <= w_err;
            r_name_len <= r_snap.name_count;
            r_size     <= (w_err == ERR_OK) ? r_snap.size_acc[31:0] : 32'd0;
            r_hash     <= (w_err == ERR_OK) ? r_snap.hash : 128'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_error_code  = r_err;
    assign o_name_length = r_name_len;
    assign o_file_size   = r_size;
    assign o_hash_high   = r_hash[127:64];
    assign o_hash_low    = r_hash[63:0];

endmodule

`default_nettype wire
